// ===== rtl/core/isc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, codes and constants of the identifier syntax checker.
// ----------------------------------------------------------------------------
package isc_pkg;

   // counter range: byte counters saturate at MAX_BYTES + 1
   localparam int MAX_BYTES  = 1023;
   localparam int CNT_W      = $clog2(MAX_BYTES + 2);
   localparam int POS_W      = 10;
   localparam int LIM_W      = 10;
   localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam int KIND_W     = 3;
   localparam int STAT_W     = 2;
   localparam int SEG_W      = 2;
   localparam int BYTE_W     = 8;

   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BYTES + 1);
   localparam logic [POS_W-1:0] POS_SAT = '1;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_NAMESPACE_LIMIT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MODULE_NAME_LIMIT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_NAME_LIMIT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FEATURE_NAME_LIMIT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MODULE_ID_LIMIT    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_ID_LIMIT   = 3'd5;

   // register reset values
   localparam logic [LIM_W-1:0] RST_NAME_LIMIT       = 10'd64;
   localparam logic [LIM_W-1:0] RST_MODULE_ID_LIMIT  = 10'd129;
   localparam logic [LIM_W-1:0] RST_PAYLOAD_ID_LIMIT = 10'd194;

   // identifier kinds
   localparam logic [KIND_W-1:0] KIND_NAMESPACE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MODULE_NAME  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD_NAME = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FEATURE_NAME = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MODULE_ID    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD_ID   = 3'd5;

   // segment types
   localparam logic [SEG_W-1:0] SEG_NAMESPACE = 2'd0;
   localparam logic [SEG_W-1:0] SEG_MODULE    = 2'd1;
   localparam logic [SEG_W-1:0] SEG_PAYLOAD   = 2'd2;
   localparam logic [SEG_W-1:0] SEG_FEATURE   = 2'd3;

   // result codes
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_INVALID  = 2'd2;

   // characters
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LC_Z  = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [LIM_W-1:0] namespace_limit;
      logic [LIM_W-1:0] module_name_limit;
      logic [LIM_W-1:0] payload_name_limit;
      logic [LIM_W-1:0] feature_name_limit;
      logic [LIM_W-1:0] module_id_limit;
      logic [LIM_W-1:0] payload_id_limit;
   } limits_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              in_progress;
      logic [CNT_W-1:0]  total_bytes;
      logic [SEG_W-1:0]  seg_num;
      logic [CNT_W-1:0]  seg_bytes;
      logic              syntax_bad;
      logic [POS_W-1:0]  colon_at;
      logic [POS_W-1:0]  slash_at;
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  colon_index;
      logic [POS_W-1:0]  slash_index;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/identifier_syntax_checker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// identifier_syntax_checker_unit
// Streaming syntax and length checker for identifier strings, one byte per
// transaction, with an APB-style register port for the length limits.
// ----------------------------------------------------------------------------
// One identifier arrives as a run of request transactions, one character
// each; the kind is sampled from the first transaction of the run and the
// transaction with req_end_of_text set closes it and yields one response
// transaction (status, colon and slash positions). The unit takes one
// request per cycle: each transaction lands in an input register, and from
// there the per-byte check and counter update write the state and
// response registers, so a response is registered once its end
// transaction leaves the input register. Only a full response register
// that is not being drained stalls the request side.
module identifier_syntax_checker_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [isc_pkg::KIND_W-1:0]           req_id_kind,
   input  wire  [isc_pkg::BYTE_W-1:0]           req_text_byte,
   input  wire                                  req_byte_present,
   input  wire                                  req_end_of_text,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [isc_pkg::STAT_W-1:0]           rsp_check_status,
   output logic [isc_pkg::POS_W-1:0]            rsp_colon_index,
   output logic [isc_pkg::POS_W-1:0]            rsp_slash_index,
   // register port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [isc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [isc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [isc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   isc_pkg::limits_type                limits_ff, limits_in;
   isc_pkg::state_type                 state_ff, state_in;
   isc_pkg::state_type                 step_state;
   isc_pkg::result_type                step_result;
   isc_pkg::result_type                rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               in_valid_ff, in_valid_in;
   logic [isc_pkg::KIND_W-1:0]         in_kind_ff, in_kind_in;
   logic [isc_pkg::BYTE_W-1:0]         in_byte_ff, in_byte_in;
   logic                               in_present_ff, in_present_in;
   logic                               in_end_ff, in_end_in;
   logic                               req_take;
   logic                               proc_go;
   logic                               csr_write;
   logic [isc_pkg::REG_IDX_W-1:0]      csr_idx;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[isc_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      limits_in = limits_ff;
      if (csr_write) begin
         case (csr_idx)
            isc_pkg::REG_NAMESPACE_LIMIT:
               limits_in.namespace_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            isc_pkg::REG_MODULE_NAME_LIMIT:
               limits_in.module_name_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            isc_pkg::REG_PAYLOAD_NAME_LIMIT:
               limits_in.payload_name_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            isc_pkg::REG_FEATURE_NAME_LIMIT:
               limits_in.feature_name_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            isc_pkg::REG_MODULE_ID_LIMIT:
               limits_in.module_id_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            isc_pkg::REG_PAYLOAD_ID_LIMIT:
               limits_in.payload_id_limit = csr_pwdata[isc_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_idx)
         isc_pkg::REG_NAMESPACE_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.namespace_limit);
         isc_pkg::REG_MODULE_NAME_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.module_name_limit);
         isc_pkg::REG_PAYLOAD_NAME_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.payload_name_limit);
         isc_pkg::REG_FEATURE_NAME_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.feature_name_limit);
         isc_pkg::REG_MODULE_ID_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.module_id_limit);
         isc_pkg::REG_PAYLOAD_ID_LIMIT:
            csr_prdata = isc_pkg::CSR_DATA_W'(limits_ff.payload_id_limit);
         default:
            csr_prdata = '0;
      endcase
   end

   // pipeline flow: a stage advances unless its response cannot be stored
   assign proc_go   = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_go;
   assign req_take  = req_valid && req_ready;

   // input register
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_kind_in    = in_kind_ff;
      in_byte_in    = in_byte_ff;
      in_present_in = in_present_ff;
      in_end_in     = in_end_ff;
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_kind_in    = req_id_kind;
         in_byte_in    = req_text_byte;
         in_present_in = req_byte_present;
         in_end_in     = req_end_of_text;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   // per-byte check logic
   isc_step u_step (
      .cur_state    (state_ff),
      .limits       (limits_ff),
      .id_kind      (in_kind_ff),
      .text_byte    (in_byte_ff),
      .byte_present (in_present_ff),
      .end_of_text  (in_end_ff),
      .nxt_state    (step_state),
      .result       (step_result)
   );

   assign state_in = proc_go ? step_state : state_ff;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (proc_go && in_end_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_check_status = rsp_ff.status;
   assign rsp_colon_index  = rsp_ff.colon_index;
   assign rsp_slash_index  = rsp_ff.slash_index;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
         state_ff                     <= '0;
         limits_ff.namespace_limit    <= isc_pkg::RST_NAME_LIMIT;
         limits_ff.module_name_limit  <= isc_pkg::RST_NAME_LIMIT;
         limits_ff.payload_name_limit <= isc_pkg::RST_NAME_LIMIT;
         limits_ff.feature_name_limit <= isc_pkg::RST_NAME_LIMIT;
         limits_ff.module_id_limit    <= isc_pkg::RST_MODULE_ID_LIMIT;
         limits_ff.payload_id_limit   <= isc_pkg::RST_PAYLOAD_ID_LIMIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         limits_ff    <= limits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_kind_ff    <= in_kind_in;
      in_byte_ff    <= in_byte_in;
      in_present_ff <= in_present_in;
      in_end_ff     <= in_end_in;
      rsp_ff        <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/isc_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isc_step
// Per-byte next-state and end-of-text result logic of the checker.
// ----------------------------------------------------------------------------
module isc_step (
   input  wire isc_pkg::state_type               cur_state,
   input  wire isc_pkg::limits_type              limits,
   input  wire logic [isc_pkg::KIND_W-1:0]       id_kind,
   input  wire logic [isc_pkg::BYTE_W-1:0]       text_byte,
   input  wire logic                             byte_present,
   input  wire logic                             end_of_text,
   output isc_pkg::state_type                    nxt_state,
   output isc_pkg::result_type                   result
);

   // limit of one segment type
   function automatic logic [isc_pkg::LIM_W-1:0] seg_limit(
      input logic [isc_pkg::SEG_W-1:0] stype,
      input isc_pkg::limits_type       lim
   );
      logic [isc_pkg::LIM_W-1:0] l;
      begin
         case (stype)
            isc_pkg::SEG_NAMESPACE: l = lim.namespace_limit;
            isc_pkg::SEG_MODULE:    l = lim.module_name_limit;
            isc_pkg::SEG_PAYLOAD:   l = lim.payload_name_limit;
            default:                l = lim.feature_name_limit;
         endcase
         return l;
      end
   endfunction

   // segment type follows the kind, or the segment number inside an id
   function automatic logic [isc_pkg::SEG_W-1:0] seg_type(input isc_pkg::state_type s);
      begin
         if (s.kind <= isc_pkg::KIND_FEATURE_NAME) begin
            return s.kind[isc_pkg::SEG_W-1:0];
         end
         return s.seg_num;
      end
   endfunction

   // a closed segment is bad when empty or over its limit
   function automatic logic seg_fails(
      input isc_pkg::state_type  s,
      input isc_pkg::limits_type lim
   );
      begin
         return (s.seg_bytes == '0) ||
                (isc_pkg::CMP_W'(s.seg_bytes) >
                 isc_pkg::CMP_W'(seg_limit(seg_type(s), lim)));
      end
   endfunction

   function automatic logic is_lower(input logic [isc_pkg::BYTE_W-1:0] c);
      return (c >= isc_pkg::CH_LC_A) && (c <= isc_pkg::CH_LC_Z);
   endfunction

   function automatic logic is_lower_alnum(input logic [isc_pkg::BYTE_W-1:0] c);
      return is_lower(c) || ((c >= isc_pkg::CH_ZERO) && (c <= isc_pkg::CH_NINE));
   endfunction

   function automatic logic is_tail(input logic [isc_pkg::BYTE_W-1:0] c);
      return is_lower_alnum(c) || (c == isc_pkg::CH_UNDER) ||
             (c == isc_pkg::CH_DOT) || (c == isc_pkg::CH_DASH);
   endfunction

   isc_pkg::state_type           base;
   logic                         is_id;
   logic [isc_pkg::POS_W-1:0]    pos_sat;
   logic [isc_pkg::SEG_W-1:0]    stype;
   logic                         char_ok;
   logic                         final_bad;
   logic [isc_pkg::LIM_W-1:0]    total_limit;

   // run start clears the state and samples the kind
   always_comb begin
      base = cur_state;
      if (!cur_state.in_progress) begin
         base      = '0;
         base.kind = id_kind;
      end
      base.in_progress = 1'b1;
   end

   assign is_id = (base.kind == isc_pkg::KIND_MODULE_ID) ||
                  (base.kind == isc_pkg::KIND_PAYLOAD_ID);

   // position of this byte, saturated to the index width
   assign pos_sat = (isc_pkg::CMP_W'(base.total_bytes) > isc_pkg::CMP_W'(isc_pkg::POS_SAT)) ?
                    isc_pkg::POS_SAT : isc_pkg::POS_W'(base.total_bytes);

   assign stype = seg_type(base);

   // character class check for the open segment
   always_comb begin
      if (base.seg_bytes == '0) begin
         char_ok = (stype == isc_pkg::SEG_FEATURE) ? is_lower(text_byte)
                                                  : is_lower_alnum(text_byte);
      end else begin
         char_ok = is_tail(text_byte) ||
                   ((stype == isc_pkg::SEG_PAYLOAD) && (text_byte == isc_pkg::CH_SLASH));
      end
   end

   // byte update
   always_comb begin
      nxt_state = base;
      if ((base.kind <= isc_pkg::KIND_PAYLOAD_ID) && byte_present) begin
         if (base.total_bytes != isc_pkg::CNT_SAT) begin
            nxt_state.total_bytes = base.total_bytes + 1'b1;
         end
         if (is_id && (text_byte == isc_pkg::CH_COLON)) begin
            if (base.seg_num != isc_pkg::SEG_NAMESPACE) begin
               nxt_state.syntax_bad = 1'b1;
            end else begin
               if (seg_fails(base, limits)) begin
                  nxt_state.syntax_bad = 1'b1;
               end
               nxt_state.colon_at  = pos_sat;
               nxt_state.seg_num   = isc_pkg::SEG_MODULE;
               nxt_state.seg_bytes = '0;
            end
         end else if ((base.kind == isc_pkg::KIND_PAYLOAD_ID) &&
                      (base.seg_num == isc_pkg::SEG_MODULE) &&
                      (text_byte == isc_pkg::CH_SLASH)) begin
            if (seg_fails(base, limits)) begin
               nxt_state.syntax_bad = 1'b1;
            end
            nxt_state.slash_at  = pos_sat;
            nxt_state.seg_num   = isc_pkg::SEG_PAYLOAD;
            nxt_state.seg_bytes = '0;
         end else begin
            if (!char_ok) begin
               nxt_state.syntax_bad = 1'b1;
            end
            if (base.seg_bytes != isc_pkg::CNT_SAT) begin
               nxt_state.seg_bytes = base.seg_bytes + 1'b1;
            end
         end
      end
      if (end_of_text) begin
         nxt_state.in_progress = 1'b0;
      end
   end

   // end-of-text checks on the updated state
   always_comb begin
      final_bad = nxt_state.syntax_bad || seg_fails(nxt_state, limits) ||
                  ((nxt_state.kind == isc_pkg::KIND_MODULE_ID) &&
                   (nxt_state.seg_num != isc_pkg::SEG_MODULE)) ||
                  ((nxt_state.kind == isc_pkg::KIND_PAYLOAD_ID) &&
                   (nxt_state.seg_num != isc_pkg::SEG_PAYLOAD));
      case (nxt_state.kind)
         isc_pkg::KIND_MODULE_ID:  total_limit = limits.module_id_limit;
         isc_pkg::KIND_PAYLOAD_ID: total_limit = limits.payload_id_limit;
         default: total_limit = seg_limit(nxt_state.kind[isc_pkg::SEG_W-1:0], limits);
      endcase
   end

   // result transaction fields
   always_comb begin
      result = '0;
      if (nxt_state.kind > isc_pkg::KIND_PAYLOAD_ID) begin
         result.status = isc_pkg::STATUS_INVALID;
      end else begin
         if (isc_pkg::CMP_W'(nxt_state.total_bytes) > isc_pkg::CMP_W'(total_limit)) begin
            result.status = isc_pkg::STATUS_TOO_LONG;
         end else if (final_bad) begin
            result.status = isc_pkg::STATUS_INVALID;
         end else begin
            result.status = isc_pkg::STATUS_OK;
         end
         if (is_id) begin
            result.colon_index = nxt_state.colon_at;
         end
         if (nxt_state.kind == isc_pkg::KIND_PAYLOAD_ID) begin
            result.slash_index = nxt_state.slash_at;
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for identifier_syntax_checker_unit. Identifiers go in
// one byte per request transaction; a behavioral copy of the checker works
// out each report that a directed row does not give, and every response is
// compared field by field with the oldest pending report. A short directed
// list comes first, then random well-formed and broken identifiers under
// several limit settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import isc_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   // random request transaction budget, split evenly among the phases
   localparam int RANDOM_ITEMS    = 248;
   localparam int PHASES          = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DIRECTED_ROWS   = 24;

   // kinds with no meaning, always reported as invalid syntax
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam string TAIL_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789_.-/";
   localparam int    LETTERS    = 26;
   localparam int    LEAD_CHARS = 36;

   localparam logic [REG_IDX_W-1:0] LIMIT_REGS [6] = '{
      REG_NAMESPACE_LIMIT, REG_MODULE_NAME_LIMIT, REG_PAYLOAD_NAME_LIMIT,
      REG_FEATURE_NAME_LIMIT, REG_MODULE_ID_LIMIT, REG_PAYLOAD_ID_LIMIT};

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   typedef struct {
      logic [KIND_W-1:0] kind;
      string             text;
      bit                lead_empty;
      bit                tail_empty;
      bit                typed;
      result_type        want;
   } directed_row_type;

   typedef struct {
      bit         typed;
      result_type want;
   } report_plan_type;

   // dut ports
   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_id_kind      = '0;
   logic [BYTE_W-1:0]     req_text_byte    = '0;
   logic                  req_byte_present = 1'b0;
   logic                  req_end_of_text  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [STAT_W-1:0]     rsp_check_status;
   logic [POS_W-1:0]      rsp_colon_index;
   logic [POS_W-1:0]      rsp_slash_index;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // checker copy: limits and per-run state
   logic [LIM_W-1:0] limit_reg [0:5];
   logic [KIND_W-1:0] run_kind   = '0;
   bit                run_open   = 1'b0;
   int unsigned       byte_total = 0;
   int unsigned       seg_len    = 0;
   logic [SEG_W-1:0]  seg_index  = '0;
   bit                syntax_err = 1'b0;
   logic [POS_W-1:0]  colon_pos  = '0;
   logic [POS_W-1:0]  slash_pos  = '0;

   result_type      expected_reports[$];
   report_plan_type report_plan[$];
   int              mismatch_count     = 0;
   int              items_sent         = 0;
   int              cycle_count        = 0;
   int              sender_gap_pct     = 0;
   int              receiver_stall_pct = 0;
   bit              hold_off_request   = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_NAMESPACE,    "a",       0, 0, 1, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_NAMESPACE,    "",        0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_FEATURE_NAME, "1x",      0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_FEATURE_NAME, "x9",      0, 0, 1, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_MODULE_NAME,  "9_.-z",   0, 0, 1, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_MODULE_NAME,  "a/b",     0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_PAYLOAD_NAME, "a/b",     0, 0, 1, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_NAMESPACE,    "_a",      0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_NAMESPACE,    "A",       0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_NAMESPACE,    "a\377",   0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_MODULE_ID,    "a:b",     0, 0, 1, '{STATUS_OK,       10'd1, 10'd0}},
      '{KIND_MODULE_ID,    "ab",      0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_MODULE_ID,    "a::b",    0, 0, 1, '{STATUS_INVALID,  10'd1, 10'd0}},
      '{KIND_MODULE_ID,    ":b",      0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_PAYLOAD_ID,   "a:b/c",   0, 0, 1, '{STATUS_OK,       10'd1, 10'd3}},
      '{KIND_PAYLOAD_ID,   "a:b/c/d", 0, 0, 1, '{STATUS_OK,       10'd1, 10'd3}},
      '{KIND_PAYLOAD_ID,   "a:/b",    0, 0, 1, '{STATUS_INVALID,  10'd1, 10'd2}},
      '{KIND_PAYLOAD_ID,   "a:b",     0, 0, 1, '{STATUS_INVALID,  10'd1, 10'd0}},
      '{KIND_SPARE_6,      "a",       0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_SPARE_7,      "",        0, 0, 1, '{STATUS_INVALID,  10'd0, 10'd0}},
      '{KIND_NAMESPACE,    "ab",      1, 0, 1, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_PAYLOAD_ID,   "a:b/c",   0, 1, 1, '{STATUS_OK,       10'd1, 10'd3}},
      '{KIND_MODULE_ID,    "a:b-9",   1, 1, 0, '{STATUS_OK,       10'd0, 10'd0}},
      '{KIND_PAYLOAD_NAME, "0z/_.",   0, 0, 0, '{STATUS_OK,       10'd0, 10'd0}}};

   identifier_syntax_checker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_id_kind      (req_id_kind),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_check_status (rsp_check_status),
      .rsp_colon_index  (rsp_colon_index),
      .rsp_slash_index  (rsp_slash_index),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // character classes
   function automatic bit is_lower(logic [BYTE_W-1:0] c);
      return c >= CH_LC_A && c <= CH_LC_Z;
   endfunction

   function automatic bit is_lead(logic [BYTE_W-1:0] c);
      return is_lower(c) || (c >= CH_ZERO && c <= CH_NINE);
   endfunction

   function automatic bit is_tail(logic [BYTE_W-1:0] c);
      return is_lead(c) || c == CH_UNDER || c == CH_DOT || c == CH_DASH;
   endfunction

   // plain kinds are their own segment type, ids walk through the segments
   function automatic logic [SEG_W-1:0] segment_type();
      return (run_kind <= KIND_FEATURE_NAME) ? run_kind[SEG_W-1:0] : seg_index;
   endfunction

   function automatic int unsigned segment_limit(logic [SEG_W-1:0] t);
      case (t)
         SEG_NAMESPACE: return limit_reg[REG_NAMESPACE_LIMIT];
         SEG_MODULE:    return limit_reg[REG_MODULE_NAME_LIMIT];
         SEG_PAYLOAD:   return limit_reg[REG_PAYLOAD_NAME_LIMIT];
         default:       return limit_reg[REG_FEATURE_NAME_LIMIT];
      endcase
   endfunction

   function automatic void close_segment();
      if (seg_len == 0 || seg_len > segment_limit(segment_type())) syntax_err = 1'b1;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(int unsigned pos);
      return (pos > POS_SAT) ? POS_SAT : POS_W'(pos);
   endfunction

   function automatic void take_byte(logic [BYTE_W-1:0] c);
      int unsigned      pos;
      logic [SEG_W-1:0] t;
      bit               ok;
      pos = byte_total;
      if (byte_total <= MAX_BYTES) byte_total++;
      // separators of module and payload ids
      if (run_kind == KIND_MODULE_ID || run_kind == KIND_PAYLOAD_ID) begin
         if (c == CH_COLON) begin
            if (seg_index != SEG_NAMESPACE) begin
               syntax_err = 1'b1;
            end else begin
               close_segment();
               colon_pos = clamp_pos(pos);
               seg_index = SEG_MODULE;
               seg_len   = 0;
            end
            return;
         end
         if (run_kind == KIND_PAYLOAD_ID && seg_index == SEG_MODULE && c == CH_SLASH) begin
            close_segment();
            slash_pos = clamp_pos(pos);
            seg_index = SEG_PAYLOAD;
            seg_len   = 0;
            return;
         end
      end
      t = segment_type();
      if (seg_len == 0) ok = (t == SEG_FEATURE) ? is_lower(c) : is_lead(c);
      else ok = is_tail(c) || (t == SEG_PAYLOAD && c == CH_SLASH);
      if (!ok) syntax_err = 1'b1;
      if (seg_len <= MAX_BYTES) seg_len++;
   endfunction

   // advance the checker copy by one transaction, returns 1 with a report on an end
   function automatic bit predict_report(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] c,
                                         bit present, bit last, output result_type r);
      int unsigned total_limit;
      r = '0;
      if (!run_open) begin
         run_kind   = kind;
         byte_total = 0;
         seg_index  = SEG_NAMESPACE;
         seg_len    = 0;
         syntax_err = 1'b0;
         colon_pos  = '0;
         slash_pos  = '0;
      end
      run_open = 1'b1;
      if (run_kind <= KIND_PAYLOAD_ID && present) take_byte(c);
      if (!last) return 1'b0;
      run_open = 1'b0;
      if (run_kind > KIND_PAYLOAD_ID) begin
         r.status = STATUS_INVALID;
         return 1'b1;
      end
      if (run_kind == KIND_MODULE_ID && seg_index != SEG_MODULE) syntax_err = 1'b1;
      if (run_kind == KIND_PAYLOAD_ID && seg_index != SEG_PAYLOAD) syntax_err = 1'b1;
      close_segment();
      case (run_kind)
         KIND_MODULE_ID:  total_limit = limit_reg[REG_MODULE_ID_LIMIT];
         KIND_PAYLOAD_ID: total_limit = limit_reg[REG_PAYLOAD_ID_LIMIT];
         default:         total_limit = segment_limit(run_kind[SEG_W-1:0]);
      endcase
      // length first, then syntax
      if (byte_total > total_limit) r.status = STATUS_TOO_LONG;
      else if (syntax_err) r.status = STATUS_INVALID;
      else r.status = STATUS_OK;
      if (run_kind >= KIND_MODULE_ID) r.colon_index = colon_pos;
      if (run_kind == KIND_PAYLOAD_ID) r.slash_index = slash_pos;
      return 1'b1;
   endfunction

   function automatic void note_mismatch(string what, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s: expected status %0d colon %0d slash %0d, got %0d %0d %0d",
                  what, want.status, want.colon_index, want.slash_index,
                  got.status, got.colon_index, got.slash_index);
   endfunction

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      result_type      predicted;
      result_type      got;
      result_type      want;
      report_plan_type plan;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (predict_report(req_id_kind, req_text_byte, req_byte_present,
                               req_end_of_text, predicted)) begin
               plan = report_plan.pop_front();
               expected_reports.insert(expected_reports.size(),
                                       plan.typed ? plan.want : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_check_status, rsp_colon_index, rsp_slash_index};
            if (expected_reports.size() == 0) begin
               note_mismatch("response transaction with no report pending", '0, got);
            end else begin
               want = expected_reports.pop_front();
               if (got.status != want.status || got.colon_index != want.colon_index ||
                   got.slash_index != want.slash_index)
                  note_mismatch("report", want, got);
            end
         end
      end
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // one request transaction, returns at the edge where it is accepted
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] c,
                            input bit present, input bit last);
      if (sender_gap_pct != 0 && $urandom_range(99, 0) < sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_id_kind      <= kind;
      req_text_byte    <= c;
      req_byte_present <= present;
      req_end_of_text  <= last;
      items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // a whole identifier; only the first transaction carries the real kind
   task automatic send_identifier(input logic [KIND_W-1:0] kind, input byte_queue_type text,
                                  input bit lead_empty, input bit tail_empty,
                                  input bit typed, input result_type want);
      bit              first;
      report_plan_type plan;
      first      = 1'b1;
      plan.typed = typed;
      plan.want  = want;
      report_plan.insert(report_plan.size(), plan);
      if (lead_empty) begin
         send_item(kind, BYTE_W'($urandom_range(255, 0)), 1'b0, 1'b0);
         first = 1'b0;
      end
      for (int i = 0; i < text.size(); i++) begin
         send_item(first ? kind : KIND_W'($urandom_range(7, 0)), text[i], 1'b1,
                   (i == text.size() - 1) && !tail_empty);
         first = 1'b0;
      end
      if (tail_empty || text.size() == 0)
         send_item(first ? kind : KIND_W'($urandom_range(7, 0)),
                   BYTE_W'($urandom_range(255, 0)), 1'b0, 1'b1);
   endtask

   // stop offering and wait until every report has come back
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      while (report_plan.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic write_limit(input logic [REG_IDX_W-1:0] idx, input logic [LIM_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {(CSR_DATA_W - LIM_W)'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      limit_reg[idx] = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void append_segment(ref byte_queue_type q, input bit feature,
                                          input bit payload);
      int len;
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 8) len = 0;
      else if (pick < 88) len = $urandom_range(6, 1);
      else len = $urandom_range(24, 7);
      for (int i = 0; i < len; i++) begin
         if (i == 0)
            q.insert(q.size(),
                     TAIL_CHARS[$urandom_range(feature ? LETTERS - 1 : LEAD_CHARS - 1, 0)]);
         else
            q.insert(q.size(),
                     TAIL_CHARS[$urandom_range(TAIL_CHARS.len() - (payload ? 1 : 2), 0)]);
      end
   endfunction

   // mostly well-formed text for the kind, a quarter of it broken on purpose
   function automatic byte_queue_type compose_text(input logic [KIND_W-1:0] kind);
      byte_queue_type q;
      int             pos;
      if (kind > KIND_PAYLOAD_ID) begin
         repeat ($urandom_range(6, 0)) q.insert(q.size(), BYTE_W'($urandom_range(255, 0)));
         return q;
      end
      append_segment(q, kind == KIND_FEATURE_NAME, kind == KIND_PAYLOAD_NAME);
      if (kind == KIND_MODULE_ID || kind == KIND_PAYLOAD_ID) begin
         q.insert(q.size(), CH_COLON);
         append_segment(q, 1'b0, 1'b0);
         if (kind == KIND_PAYLOAD_ID) begin
            q.insert(q.size(), CH_SLASH);
            append_segment(q, 1'b0, 1'b1);
         end
      end
      if ($urandom_range(99, 0) < 25) begin
         pos = $urandom_range(q.size(), 0);
         case ($urandom_range(3, 0))
            0: if (pos < q.size()) q[pos] = BYTE_W'($urandom_range(255, 0));
            1: q.insert(pos, CH_COLON);
            2: if (pos < q.size()) q.delete(pos);
            default: q.insert(pos, CH_SLASH);
         endcase
      end
      return q;
   endfunction

   // limit setting of a phase: zeros, maximum, reset values, else random
   function automatic logic [LIM_W-1:0] phase_limit(int phase, logic [REG_IDX_W-1:0] idx);
      int pick;
      if (phase == 0) return '0;
      if (phase == 1) return '1;
      if (phase == PHASES - 1) begin
         if (idx == REG_MODULE_ID_LIMIT) return RST_MODULE_ID_LIMIT;
         if (idx == REG_PAYLOAD_ID_LIMIT) return RST_PAYLOAD_ID_LIMIT;
         return RST_NAME_LIMIT;
      end
      pick = $urandom_range(99, 0);
      if (pick < 50) return LIM_W'($urandom_range(15, 0));
      if (pick < 75) return LIM_W'($urandom_range(40, 16));
      return LIM_W'($urandom_range(1023, 0));
   endfunction

   // stimulus
   initial begin
      byte_queue_type    text;
      logic [KIND_W-1:0] kind;
      int                phase_end;
      limit_reg[REG_NAMESPACE_LIMIT]    = RST_NAME_LIMIT;
      limit_reg[REG_MODULE_NAME_LIMIT]  = RST_NAME_LIMIT;
      limit_reg[REG_PAYLOAD_NAME_LIMIT] = RST_NAME_LIMIT;
      limit_reg[REG_FEATURE_NAME_LIMIT] = RST_NAME_LIMIT;
      limit_reg[REG_MODULE_ID_LIMIT]    = RST_MODULE_ID_LIMIT;
      limit_reg[REG_PAYLOAD_ID_LIMIT]   = RST_PAYLOAD_ID_LIMIT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed list at reset limits
      foreach (directed_rows[r]) begin
         text = {};
         for (int c = 0; c < directed_rows[r].text.len(); c++)
            text.insert(text.size(), directed_rows[r].text[c]);
         send_identifier(directed_rows[r].kind, text, directed_rows[r].lead_empty,
                         directed_rows[r].tail_empty, directed_rows[r].typed,
                         directed_rows[r].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_reports();
         foreach (LIMIT_REGS[r]) write_limit(LIMIT_REGS[r], phase_limit(phase, LIMIT_REGS[r]));
         case (phase % 4)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_gap_pct = 24; receiver_stall_pct = 24; end
         endcase
         // long hold-off on the response side while requests keep coming
         if (phase == 2) hold_off_request = 1'b1;
         // saturating counters and positions at maximum limits
         if (phase == 1) begin
            text = {};
            repeat (MAX_BYTES + 1) text.insert(text.size(), CH_LC_A);
            text.insert(text.size(), CH_COLON);
            text.insert(text.size(), CH_LC_Z);
            text.insert(text.size(), CH_SLASH);
            text.insert(text.size(), CH_ZERO);
            send_identifier(KIND_PAYLOAD_ID, text, 1'b0, 1'b0, 1'b0, '0);
         end
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            if ($urandom_range(99, 0) < 6) kind = KIND_W'($urandom_range(7, 6));
            else kind = KIND_W'($urandom_range(5, 0));
            send_identifier(kind, compose_text(kind), $urandom_range(99, 0) < 8,
                            $urandom_range(99, 0) < 10, 1'b0, '0);
         end
      end

      wait_for_reports();
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
